// ===== sv/pc_pkg.sv =====
package pc_pkg;

  // full-width pixel address, wide enough for any 12-bit row times 13-bit row width
  localparam int unsigned AddrFullW = 25;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;
  localparam logic [12:0] LineWidthRst = 13'd256;
  localparam logic [7:0]  ByteFull     = 8'hFF;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_FILL    = 3'd1,
    ACT_BLIT    = 3'd2,
    ACT_BLEND   = 3'd3,
    ACT_STENCIL = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    FMT_RGBA = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_GREY = 2'd2
  } color_fmt_e;

  typedef enum logic [2:0] {
    CFG_LINE_WIDTH = 3'd0,
    CFG_FOUR_BYTE  = 3'd1,
    CFG_SWAP_RB    = 3'd2,
    CFG_COLOR_FMT  = 3'd3,
    CFG_COLOR0     = 3'd4,
    CFG_COLOR1     = 3'd5,
    CFG_COLOR2     = 3'd6,
    CFG_COLOR3     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CALC
  } state_e;

  // word layout of the frame store: red in the low byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic       four_byte;
    logic       swap_rb;
    logic [1:0] color_fmt;
    logic [7:0] color0;
    logic [7:0] color1;
    logic [7:0] color2;
    logic [7:0] color3;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [7:0] coverage;
  } src_t;

endpackage

// ===== sv/pc_frame_mem.sv =====
module pc_frame_mem #(
  parameter int unsigned Depth = 65536,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [31:0]      wr_data_i,
  output logic [31:0]      rd_data_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/pc_blend_alu.sv =====
module pc_blend_alu (
  input  logic [2:0]    action_i,
  input  pc_pkg::cfg_t  cfg_i,
  input  pc_pkg::src_t  src_i,
  input  pc_pkg::pix_t  dst_i,
  output pc_pkg::pix_t  pix_o
);
  import pc_pkg::*;

  // (d*(255-a) + c*a) >> 8, kept to 8 bits
  function automatic logic [7:0] mix_cov(logic [7:0] d, logic [8:0] c, logic [7:0] a);
    logic [16:0] sum;
    sum = 17'(d) * 17'(ByteFull - a) + 17'(c) * 17'(a);
    return sum[15:8];
  endfunction

  // ((d*(255-a)) >> 8) + s, kept to 8 bits
  function automatic logic [7:0] blend_pm(logic [7:0] d, logic [7:0] s, logic [7:0] a);
    logic [15:0] prod;
    prod = 16'(d) * 16'(ByteFull - a);
    return prod[15:8] + s;
  endfunction

  logic [7:0] d_alpha;
  logic [7:0] col_r;
  logic [7:0] col_b;
  logic [7:0] mix_a;
  pix_t       mix_pix;
  pix_t       blend_pix;
  pix_t       new_pix;

  assign d_alpha = cfg_i.four_byte ? dst_i.alpha : 8'd0;
  assign col_r   = cfg_i.swap_rb ? cfg_i.color2 : cfg_i.color0;
  assign col_b   = cfg_i.swap_rb ? cfg_i.color0 : cfg_i.color2;

  // fill weighs by colour alpha, stencil by coverage
  assign mix_a = (action_i == ACT_STENCIL) ? src_i.coverage : cfg_i.color3;

  always_comb begin
    mix_pix.red   = mix_cov(dst_i.red,   {1'b0, col_r},        mix_a);
    mix_pix.green = mix_cov(dst_i.green, {1'b0, cfg_i.color1}, mix_a);
    mix_pix.blue  = mix_cov(dst_i.blue,  {1'b0, col_b},        mix_a);
    mix_pix.alpha = mix_cov(d_alpha,     9'h100,               mix_a);

    blend_pix.red   = blend_pm(dst_i.red,   src_i.red,   src_i.alpha);
    blend_pix.green = blend_pm(dst_i.green, src_i.green, src_i.alpha);
    blend_pix.blue  = blend_pm(dst_i.blue,  src_i.blue,  src_i.alpha);
    blend_pix.alpha = blend_pm(d_alpha,     src_i.alpha, src_i.alpha);
  end

  always_comb begin
    new_pix = '0;
    unique case (action_i)
      ACT_CLEAR: begin
        new_pix = '0;
      end
      ACT_FILL: begin
        unique case (cfg_i.color_fmt)
          FMT_RGBA: new_pix = mix_pix;
          FMT_RGB:  new_pix = '{alpha: ByteFull, blue: col_b, green: cfg_i.color1, red: col_r};
          default:  new_pix = '{alpha: ByteFull, blue: cfg_i.color0,
                                green: cfg_i.color0, red: cfg_i.color0};
        endcase
      end
      ACT_BLIT: begin
        new_pix = '{alpha: ByteFull, blue: src_i.blue, green: src_i.green, red: src_i.red};
      end
      ACT_BLEND: begin
        if (src_i.has_alpha) begin
          new_pix = blend_pix;
        end else begin
          new_pix = '{alpha: ByteFull, blue: src_i.blue, green: src_i.green, red: src_i.red};
        end
      end
      ACT_STENCIL: begin
        new_pix = mix_pix;
      end
      default: begin
        new_pix = '0;
      end
    endcase
    if (!cfg_i.four_byte) begin
      new_pix.alpha = 8'd0;
    end
  end

  assign pix_o = new_pix;

endmodule

// ===== sv/pixel_compositor_top.sv =====
// pixel compositor: read-modify-write engine over a simple dual-port frame store
//
// input channel (in_valid_i / in_stall_o) carries one pixel action per transfer:
// clear, fill, blit, premultiplied blend or stencil blend at y*line_width+x
// output channel (out_valid_o / out_stall_i) returns one result per input transfer:
// the pixel after the action, or out_of_range with zero colour and no write
// the user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i only while idle; unchecked
//
// from input transfer to result in the output register, each item passes ST_ADDR, for
// the address multiply and the memory read, then ST_CALC, for the blend and the
// write-back; the next item is taken in the cycle after the write-back, so the block
// takes no new item until the last one is written back
// a finished result may wait in the output register while the next item is taken;
// the write-back of that next item waits until the output register is free
// reset clears the controller and restores the register defaults; the frame store
// is not cleared and must be written before it is read, so no clearing pass runs
module pixel_compositor_top #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [pc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pc_pkg::CfgDataW-1:0]    cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     action_i,
  input  logic [11:0]                    pixel_x_i,
  input  logic [11:0]                    pixel_y_i,
  input  logic [7:0]                     src_red_i,
  input  logic [7:0]                     src_green_i,
  input  logic [7:0]                     src_blue_i,
  input  logic [7:0]                     src_alpha_i,
  input  logic                           src_has_alpha_i,
  input  logic [7:0]                     coverage_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_red_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_blue_o,
  output logic [7:0]                     out_alpha_o,
  output logic                           out_of_range_o
);
  import pc_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_PIXELS);
  localparam logic [AddrFullW-1:0] MaxPix = AddrFullW'(MAX_PIXELS);

  // control state
  state_e      state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // configuration registers
  logic [12:0] line_width_q;
  cfg_t        cfg_q;

  // item held through the read-modify-write
  logic [2:0]  act_q;
  logic [11:0] x_q;
  logic [11:0] y_q;
  src_t        src_q;
  logic [AddrW-1:0] addr_q;
  logic        oor_q;

  // output register payload
  pix_t        out_pix_q;
  logic        out_oor_q;

  logic        in_xfer;
  logic        rd_en;
  logic        mem_we;
  logic        out_load;
  logic        out_free;
  logic [AddrFullW-1:0] addr_full;
  logic        oor_d;
  logic [31:0] rd_data;
  pix_t        new_pix;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // row-major address: 12 x 13 bit product plus column
  assign addr_full = AddrFullW'(y_q) * AddrFullW'(line_width_q) + AddrFullW'(x_q);
  assign oor_d     = ({1'b0, x_q} >= line_width_q) || (addr_full >= MaxPix);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_CALC;
      ST_CALC: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_ADDR: rd_en = 1'b1;
      ST_CALC: out_load = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  // undefined actions and bad addresses leave the store alone
  assign mem_we = out_load && !oor_q && (act_q <= ACT_STENCIL);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration writes, one register per index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q    <= LineWidthRst;
      cfg_q.four_byte <= 1'b1;
      cfg_q.swap_rb   <= 1'b0;
      cfg_q.color_fmt <= FMT_RGBA;
      cfg_q.color0    <= 8'd0;
      cfg_q.color1    <= 8'd0;
      cfg_q.color2    <= 8'd0;
      cfg_q.color3    <= ByteFull;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_WIDTH: line_width_q    <= cfg_data_i;
        CFG_FOUR_BYTE:  cfg_q.four_byte <= cfg_data_i[0];
        CFG_SWAP_RB:    cfg_q.swap_rb   <= cfg_data_i[0];
        CFG_COLOR_FMT:  cfg_q.color_fmt <= cfg_data_i[1:0];
        CFG_COLOR0:     cfg_q.color0    <= cfg_data_i[7:0];
        CFG_COLOR1:     cfg_q.color1    <= cfg_data_i[7:0];
        CFG_COLOR2:     cfg_q.color2    <= cfg_data_i[7:0];
        CFG_COLOR3:     cfg_q.color3    <= cfg_data_i[7:0];
        default:        line_width_q    <= line_width_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q           <= action_i;
      x_q             <= pixel_x_i;
      y_q             <= pixel_y_i;
      src_q.red       <= src_red_i;
      src_q.green     <= src_green_i;
      src_q.blue      <= src_blue_i;
      src_q.alpha     <= src_alpha_i;
      src_q.has_alpha <= src_has_alpha_i;
      src_q.coverage  <= coverage_i;
    end
    if (rd_en) begin
      addr_q <= addr_full[AddrW-1:0];
      oor_q  <= oor_d;
    end
    if (out_load) begin
      out_pix_q <= oor_q ? '0 : new_pix;
      out_oor_q <= oor_q;
    end
  end

  pc_frame_mem #(
    .Depth (MAX_PIXELS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_full[AddrW-1:0]),
    .wr_en_i   (mem_we),
    .wr_addr_i (addr_q),
    .wr_data_i (new_pix),
    .rd_data_o (rd_data)
  );

  pc_blend_alu u_alu (
    .action_i (act_q),
    .cfg_i    (cfg_q),
    .src_i    (src_q),
    .dst_i    (pix_t'(rd_data)),
    .pix_o    (new_pix)
  );

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_pix_q.red;
  assign out_green_o    = out_pix_q.green;
  assign out_blue_o     = out_pix_q.blue;
  assign out_alpha_o    = out_pix_q.alpha;
  assign out_of_range_o = out_oor_q;

  // an accepted item passes through ST_ADDR and then reaches the write-back stage ST_CALC
  a_item_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_ADDR) ##1 (state_q == ST_CALC))
    else $error("item did not reach write-back in time");

  // a store write always loads a result into the output register
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> out_valid_q)
    else $error("store written without a result");

  // a fresh result only ever comes from the write-back stage
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_CALC))
    else $error("result appeared outside write-back");

  // no new item while the output still waits on the previous write-back stage
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && !out_free) |=> (state_q == ST_CALC))
    else $error("write-back left while output register full");

endmodule
